### hw/rtl/indent_dedent_stack_unit_assert.svh
// Assertion macros for the indentation stack unit.
// Used by indent_dedent_stack_unit.sv; the includer must have clk_i and rst_ni in scope.
`ifndef INDENT_DEDENT_STACK_UNIT_ASSERT_SVH
`define INDENT_DEDENT_STACK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/idds_pkg.sv
// Package for the indentation stack unit: sizes, codes and transaction types.
// Has no dependencies; used by idds_cell, indent_dedent_stack_unit and the testbench.
package idds_pkg;

  // Stack size and level width.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned LEVEL_BITS  = 12;
  localparam int unsigned DEPTH_BITS  = $clog2(STACK_DEPTH + 1);

  // Field widths of a transaction and of the tab width register.
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned TABW_BITS  = 5;
  localparam int unsigned RAW_BITS   = COUNT_BITS + TABW_BITS + 1;
  localparam int unsigned CALC_BITS  = (LEVEL_BITS > RAW_BITS) ? LEVEL_BITS : RAW_BITS;

  localparam logic [TABW_BITS-1:0]  TAB_WIDTH_RESET = TABW_BITS'(8);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX       = '1;

  typedef enum logic {
    OP_LINE = 1'b0,
    OP_EOF  = 1'b1
  } idds_op_e;

  typedef enum logic [1:0] {
    KIND_INDENT   = 2'd0,
    KIND_DEDENT   = 2'd1,
    KIND_OVERFLOW = 2'd2
  } idds_kind_e;

  typedef struct packed {
    idds_op_e              op;
    logic [COUNT_BITS-1:0] space_count;
    logic [COUNT_BITS-1:0] tab_count;
  } idds_in_t;

  typedef struct packed {
    idds_kind_e            token_kind;
    logic [LEVEL_BITS-1:0] level;
    logic                  last;
  } idds_out_t;

  // Shift command broadcast along the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } idds_shift_t;

endpackage

### hw/rtl/idds_cell.sv
// One entry of the shifting level stack.
// Depends on idds_pkg for the level width and the shift command type.
module idds_cell (
  input  logic                              clk_i,
  input  idds_pkg::idds_shift_t             shift_i,
  input  logic [idds_pkg::LEVEL_BITS-1:0]   up_i,
  input  logic [idds_pkg::LEVEL_BITS-1:0]   down_i,
  output logic [idds_pkg::LEVEL_BITS-1:0]   level_o
);
  import idds_pkg::*;

  logic [LEVEL_BITS-1:0] level_q, level_d;

  // A push takes the entry from the neighbour nearer the top, a pop the one further down.
  always_comb begin
    level_d = level_q;
    if (shift_i.push) begin
      level_d = up_i;
    end else if (shift_i.pop) begin
      level_d = down_i;
    end
  end

  // Stack contents are undefined until written, so the entry has no reset.
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
  end

  assign level_o = level_q;

endmodule

### hw/rtl/indent_dedent_stack_unit.sv
// Order: an indent or overflow is emitted from S_EVAL, a line-start dedent from S_DEDENT after
// S_EVAL, and an end-of-input dedent from S_EOI; each result then sits in the output register.
// Any line or end of input holds in_stall_o high until the unit is back in S_IDLE, so no new
// one is taken before the last one's tokens are all emitted; a stalled waiting result holds emission.
// Reset: stack depth returns to zero and tab width to eight; stack cells are not cleared.
// The stack is a row of idds_cell instances; cell zero holds the top entry.
`include "indent_dedent_stack_unit_assert.svh"

module indent_dedent_stack_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [idds_pkg::TABW_BITS-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  idds_pkg::idds_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output idds_pkg::idds_out_t              out_data_o
);
  import idds_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DEDENT,
    S_EOI
  } state_e;

  state_e                 state_q, state_d;
  logic [DEPTH_BITS-1:0]  depth_q, depth_d;
  logic [TABW_BITS-1:0]   tab_width_q;
  logic                   out_valid_q, out_valid_d;
  idds_out_t              out_q, emit_data;
  logic                   emit, emit_ok, accept;
  logic [LEVEL_BITS-1:0]  lvl_q, lvl_sat, top_level, next_top;
  logic [CALC_BITS-1:0]   lvl_raw;
  idds_shift_t            shift;
  logic [LEVEL_BITS-1:0]  cell_lvl [STACK_DEPTH];

  // Row of stack cells, each shifting towards its neighbours on push or pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [LEVEL_BITS-1:0] up_lvl, down_lvl;
    if (i == 0) begin : g_first
      assign up_lvl = lvl_q;
    end else begin : g_mid
      assign up_lvl = cell_lvl[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign down_lvl = cell_lvl[i];
    end else begin : g_inner
      assign down_lvl = cell_lvl[i+1];
    end
    idds_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .up_i    (up_lvl),
      .down_i  (down_lvl),
      .level_o (cell_lvl[i])
    );
  end

  // Indentation level of an incoming line, saturated to the level width.
  always_comb begin
    lvl_raw = CALC_BITS'(in_data_i.space_count)
            + CALC_BITS'(in_data_i.tab_count) * CALC_BITS'(tab_width_q);
    if (lvl_raw > CALC_BITS'(LEVEL_MAX)) begin
      lvl_sat = LEVEL_MAX;
    end else begin
      lvl_sat = lvl_raw[LEVEL_BITS-1:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign top_level  = (depth_q != '0) ? cell_lvl[0] : '0;
  assign next_top   = (depth_q > DEPTH_BITS'(1)) ? cell_lvl[1] : '0;

  // Sequencer: compare, then push once (or flag overflow) or pop one entry per cycle while the output is not stalled.
  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    shift       = '0;
    emit        = 1'b0;
    emit_data   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.op == OP_EOF) ? S_EOI : S_EVAL;
        end
      end
      S_EVAL: begin
        if (lvl_q > top_level) begin
          if (emit_ok) begin
            emit            = 1'b1;
            emit_data.level = lvl_q;
            emit_data.last  = 1'b1;
            if (depth_q < DEPTH_BITS'(STACK_DEPTH)) begin
              emit_data.token_kind = KIND_INDENT;
              shift.push           = 1'b1;
              depth_d              = depth_q + DEPTH_BITS'(1);
            end else begin
              emit_data.token_kind = KIND_OVERFLOW;
            end
            state_d = S_IDLE;
          end
        end else if (lvl_q < top_level) begin
          state_d = S_DEDENT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DEDENT: begin
        if (emit_ok) begin
          emit                 = 1'b1;
          shift.pop            = 1'b1;
          depth_d              = depth_q - DEPTH_BITS'(1);
          emit_data.token_kind = KIND_DEDENT;
          emit_data.level      = next_top;
          emit_data.last       = !((lvl_q < next_top) && (next_top != '0));
          if (emit_data.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EOI: begin
        if (depth_q == '0) begin
          state_d = S_IDLE;
        end else if (emit_ok) begin
          emit                 = 1'b1;
          shift.pop            = 1'b1;
          depth_d              = depth_q - DEPTH_BITS'(1);
          emit_data.token_kind = KIND_DEDENT;
          emit_data.level      = '0;
          emit_data.last       = (depth_q == DEPTH_BITS'(1));
          if (emit_data.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state, output valid and the tab width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      tab_width_q <= TAB_WIDTH_RESET;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tab_width_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: the line level and the pending result transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q <= lvl_sat;
    end
    if (emit) begin
      out_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the stack bookkeeping.
  `IDDS_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DEPTH_BITS'(STACK_DEPTH), "stack depth overrun")
  `IDDS_ASSERT_NEXT(a_indent_push, emit && (emit_data.token_kind == KIND_INDENT), depth_q == $past(depth_q) + DEPTH_BITS'(1), "indent without push")
  `IDDS_ASSERT_NEXT(a_dedent_pop, emit && (emit_data.token_kind == KIND_DEDENT), depth_q == $past(depth_q) - DEPTH_BITS'(1), "dedent without pop")
  `IDDS_ASSERT_NEXT(a_eoi_empty, emit && (state_q == S_EOI) && emit_data.last, depth_q == '0, "stack not empty after end of input")

endmodule

### verif/tb_indent_dedent_stack_unit.sv
// Self-checking testbench for indent_dedent_stack_unit: a directed table, then random phases.
// Depends on idds_pkg and the unit's RTL; a built-in predictor or the table gives each token.
module tb_indent_dedent_stack_unit;
  import idds_pkg::*;

  localparam int unsigned PHASE_LINES  = 47;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // One row of the directed table; a row with reps above one steps space_count each time.
  typedef struct {
    idds_in_t    line;
    int unsigned reps;
    bit          typed;
    idds_out_t   token;
  } line_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i    = 1'b0;
  logic [TABW_BITS-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  idds_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  idds_out_t            out_data_o;

  // Predictor state: tab width, stack of levels and the tokens still to arrive.
  logic [TABW_BITS-1:0]  tab_cols = TAB_WIDTH_RESET;
  logic [LEVEL_BITS-1:0] lvl_stack [STACK_DEPTH];
  int unsigned           lvl_depth = 0;
  idds_out_t             token_q [$];

  int unsigned mismatches    = 0;
  int unsigned tokens_seen   = 0;
  int unsigned lines_sent    = 0;
  int unsigned busy_lines    = 0;
  int unsigned drv_calm      = 0;
  int unsigned cycle_count   = 0;
  int unsigned sink_hold     = 0;
  int unsigned sink_calm     = 0;

  line_row_t dir_rows [15] = '{
    '{'{OP_LINE, 8'd0,   8'd0},   1,  1'b0, '0},
    '{'{OP_EOF,  8'd0,   8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd4,   8'd0},   1,  1'b1, '{KIND_INDENT, 12'd4, 1'b1}},
    '{'{OP_LINE, 8'd0,   8'd1},   1,  1'b1, '{KIND_INDENT, 12'd8, 1'b1}},
    '{'{OP_LINE, 8'd255, 8'd255}, 1,  1'b1, '{KIND_INDENT, 12'd2295, 1'b1}},
    '{'{OP_LINE, 8'd0,   8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd3,   8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd7,   8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd5,   8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd1,   8'd0},   1,  1'b1, '{KIND_DEDENT, 12'd0, 1'b1}},
    '{'{OP_LINE, 8'd1,   8'd0},   16, 1'b0, '0},
    '{'{OP_LINE, 8'd255, 8'd0},   1,  1'b1, '{KIND_OVERFLOW, 12'd255, 1'b1}},
    '{'{OP_LINE, 8'd16,  8'd0},   1,  1'b0, '0},
    '{'{OP_LINE, 8'd5,   8'd0},   1,  1'b0, '0},
    '{'{OP_EOF,  8'd0,   8'd0},   1,  1'b0, '0}
  };

  indent_dedent_stack_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock, reset and cycle counter.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] stack_top();
    return (lvl_depth == 0) ? '0 : lvl_stack[lvl_depth-1];
  endfunction

  // Indentation predictor: updates the stack and returns the tokens one line causes.
  function automatic void predict_tokens(input idds_in_t line, output idds_out_t toks [$]);
    int unsigned           lvl;
    logic [LEVEL_BITS-1:0] top;
    toks = {};
    if (line.op == OP_EOF) begin
      while (lvl_depth > 0) begin
        lvl_depth--;
        toks.push_back('{KIND_DEDENT, '0, 1'b0});
      end
    end else begin
      lvl = int'(line.space_count) + int'(line.tab_count) * int'(tab_cols);
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      top = stack_top();
      if (lvl > top) begin
        if (lvl_depth < STACK_DEPTH) begin
          lvl_stack[lvl_depth] = LEVEL_BITS'(lvl);
          lvl_depth++;
          toks.push_back('{KIND_INDENT, LEVEL_BITS'(lvl), 1'b0});
        end else begin
          toks.push_back('{KIND_OVERFLOW, LEVEL_BITS'(lvl), 1'b0});
        end
      end else if (lvl < top) begin
        // Pop until the line is no longer below the top, or the base is reached.
        do begin
          if (lvl_depth > 0) lvl_depth--;
          top = stack_top();
          toks.push_back('{KIND_DEDENT, top, 1'b0});
        end while (lvl < top && top != 0 && toks.size() < STACK_DEPTH);
      end
    end
    if (toks.size() > 0) toks[toks.size()-1].last = 1'b1;
  endfunction

  // Splits a target level into spaces and tabs at the current tab width.
  function automatic idds_in_t encode_level(input int unsigned target);
    idds_in_t    line;
    int unsigned max_tabs;
    int unsigned spaces;
    line.op = OP_LINE;
    if (tab_cols == 0) begin
      line.tab_count   = COUNT_BITS'($urandom_range(0, 255));
      line.space_count = (target > 255) ? 8'd255 : COUNT_BITS'(target);
    end else begin
      max_tabs = target / tab_cols;
      if (max_tabs > 255) max_tabs = 255;
      line.tab_count = ($urandom_range(0, 1) == 1) ? COUNT_BITS'(max_tabs)
                                                   : COUNT_BITS'($urandom_range(0, max_tabs));
      spaces = target - line.tab_count * tab_cols;
      if (spaces > 255) begin
        line.tab_count = COUNT_BITS'(max_tabs);
        spaces = target - max_tabs * tab_cols;
      end
      line.space_count = (spaces > 255) ? 8'd255 : COUNT_BITS'(spaces);
    end
    return line;
  endfunction

  // Random line: mostly nested-block structure, with some noise and end-of-input items.
  function automatic idds_in_t next_line();
    idds_in_t    line;
    int unsigned r;
    int unsigned target;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      line.op          = OP_EOF;
      line.space_count = COUNT_BITS'($urandom_range(0, 255));
      line.tab_count   = COUNT_BITS'($urandom_range(0, 255));
      return line;
    end
    if (r < 14) begin
      line.op          = OP_LINE;
      line.space_count = COUNT_BITS'($urandom_range(0, 255));
      line.tab_count   = COUNT_BITS'($urandom_range(0, 255));
      return line;
    end
    if (r < 44) begin
      target = stack_top();
    end else if (r < 74) begin
      if (tab_cols != 0 && $urandom_range(0, 1) == 1) target = stack_top() + tab_cols;
      else target = stack_top() + $urandom_range(1, 8);
    end else begin
      // Go back to a stacked level or to zero, sometimes to one just below it.
      idx    = $urandom_range(0, lvl_depth);
      target = (idx == 0) ? 0 : lvl_stack[idx-1];
      if (target > 0 && $urandom_range(0, 3) == 0) target--;
    end
    return encode_level(target);
  endfunction

  // Sends one line transaction and queues the tokens it should cause.
  task automatic send_line(input idds_in_t line, input bit typed, input idds_out_t token);
    idds_out_t   toks [$];
    int unsigned gap;
    if (drv_calm > 0) begin
      drv_calm--;
      gap = 0;
    end else if ($urandom_range(0, 99) < 4) begin
      drv_calm = $urandom_range(15, 40);
      gap = 0;
    end else begin
      gap = idle_span();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= line;
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens(line, toks);
    if (typed) token_q.push_back(token);
    else foreach (toks[i]) token_q.push_back(toks[i]);
    lines_sent++;
    if (toks.size() > 0) busy_lines++;
  endtask

  // Waits until every token has arrived and the unit has had time to finish silent work.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tab_width(input logic [TABW_BITS-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tab_cols = cols;
  endtask

  task automatic report_mismatch(input string what, input idds_out_t want, input idds_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s): expected kind %0d level %0d last %0d, got kind %0d level %0d last %0d",
               what, want.token_kind, want.level, want.last,
               got.token_kind, got.level, got.last);
  endtask

  // Output side: random stalls with calm stretches.
  always @(posedge clk_i) begin : sink_stall
    int unsigned span;
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_calm > 0) begin
      sink_calm   <= sink_calm - 1;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      sink_calm   <= $urandom_range(20, 80);
      out_stall_i <= 1'b0;
    end else begin
      span = idle_span();
      out_stall_i <= (span > 0);
      sink_hold   <= (span > 0) ? span - 1 : 0;
    end
  end

  // Compares each accepted token transaction with the oldest expectation, field by field.
  always @(posedge clk_i) begin : token_check
    idds_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tokens_seen++;
      if (token_q.size() == 0) begin
        report_mismatch("no token expected", '0, out_data_o);
      end else begin
        want = token_q.pop_front();
        if (out_data_o.token_kind !== want.token_kind || out_data_o.level !== want.level ||
            out_data_o.last !== want.last)
          report_mismatch("wrong field", want, out_data_o);
      end
    end
  end

  // Stimulus: directed table at the reset tab width, then random phases at several widths.
  initial begin : stimulus
    logic [TABW_BITS-1:0] widths [6];
    idds_in_t             line;
    int unsigned          start;
    widths = '{5'd1, 5'd16, 5'd0, 5'd31,
               TABW_BITS'($urandom_range(2, 15)), TABW_BITS'($urandom_range(1, 16))};
    wait (rst_ni);
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
        line = dir_rows[r].line;
        line.space_count = line.space_count + COUNT_BITS'(k);
        send_line(line, dir_rows[r].typed, dir_rows[r].token);
      end
    end

    foreach (widths[p]) begin
      settle();
      write_tab_width(widths[p]);
      start = lines_sent;
      while (lines_sent - start < PHASE_LINES) send_line(next_line(), 1'b0, '0);
    end
    settle();

    $display("Run covered %0d line transactions (%0d causing tokens), %0d tokens checked,",
             lines_sent, busy_lines, tokens_seen);
    $display("at tab widths 8, 1, 16, 0, 31, %0d and %0d; %0d mismatches.",
             widths[4], widths[5], mismatches);
    if (mismatches == 0) begin
      $display("tb_indent_dedent_stack_unit: done, clean");
    end else begin
      $display("tb_indent_dedent_stack_unit: done, errors");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_indent_dedent_stack_unit: done, errors");
    $finish;
  end

endmodule
